// ----- rtl/tbp_pkg.sv -----
`timescale 1ns / 1ps
// tbp_pkg: shared types, command codes and helpers for the tournament branch predictor
// no dependencies; imported by tbp_ctrl, tbp_datapath and tournament_branch_predictor

package tbp_pkg;

    localparam int INSTR_ADDR_BITS = 32;
    localparam int GLOBAL_CNT_BITS = 2;

    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_UPDATE  = 1'b1;

    typedef struct packed {
        logic                       command;
        logic [INSTR_ADDR_BITS-1:0] instr_addr;
        logic                       branch_taken;
    } in_word_t;

    typedef struct packed {
        logic predict_taken;
        logic is_prediction;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic rd_hist;
        logic rd_pred_cnt;
        logic rd_upd_cnt;
        logic fin_pred;
        logic fin_upd;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } dp_sts_t;

    // 2-bit saturating counter step
    function automatic logic [GLOBAL_CNT_BITS-1:0] sat2_step(
        input logic [GLOBAL_CNT_BITS-1:0] cnt,
        input logic                       up
    );
        logic [GLOBAL_CNT_BITS-1:0] res;
        res = cnt;
        if (up) begin
            if (cnt != '1) res = cnt + GLOBAL_CNT_BITS'(1);
        end else begin
            if (cnt != '0) res = cnt - GLOBAL_CNT_BITS'(1);
        end
        return res;
    endfunction

endpackage

// ----- rtl/tbp_ram.sv -----
`timescale 1ns / 1ps
// tbp_ram: generic single write, single read ram with registered read data
// no dependencies

module tbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tbp_ctrl.sv -----
`timescale 1ns / 1ps
// tbp_ctrl: sequencer for clear pass, predict and update words
// depends on tbp_pkg; drives ctrl_cmd_t into tbp_datapath

module tbp_ctrl
    import tbp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_command,
    output logic      s_ready,
    input  dp_sts_t   sts,
    output ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PRED_HIST,
        ST_PRED_CNT,
        ST_UPD_CNT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd             = '0;
        cmd.clear_wr    = (state_reg == ST_CLEAR);
        cmd.rd_hist     = accept && (s_command == CMD_PREDICT);
        cmd.rd_upd_cnt  = accept && (s_command == CMD_UPDATE);
        cmd.rd_pred_cnt = (state_reg == ST_PRED_HIST);
        cmd.fin_pred    = (state_reg == ST_PRED_CNT) && !sts.out_busy;
        cmd.fin_upd     = (state_reg == ST_UPD_CNT) && !sts.out_busy;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_command == CMD_PREDICT) ? ST_PRED_HIST : ST_UPD_CNT;
                end
            end
            ST_PRED_HIST: begin
                state_next = ST_PRED_CNT;
            end
            ST_PRED_CNT: begin
                if (!sts.out_busy) state_next = ST_IDLE;
            end
            ST_UPD_CNT: begin
                if (!sts.out_busy) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_pred_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_hist |=> cmd.rd_pred_cnt)
        else $error("predict history read not followed by counter read");

    a_upd_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_upd_cnt |=> (state_reg == ST_UPD_CNT))
        else $error("update accept did not enter counter stage");

    a_clear_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(cmd.clear_wr) |-> $past(sts.clear_last))
        else $error("clear pass ended before last entry");
`endif

endmodule

// ----- rtl/tbp_datapath.sv -----
`timescale 1ns / 1ps
// tbp_datapath: history and counter rams, path history, saved context and output register
// depends on tbp_pkg and tbp_ram; driven by tbp_ctrl

module tbp_datapath
    import tbp_pkg::*;
#(
    parameter int LOCAL_ENTRIES      = 1024,
    parameter int LOCAL_HISTORY_BITS = 10,
    parameter int LOCAL_COUNTER_BITS = 3,
    parameter int PATH_HISTORY_BITS  = 12
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_word_t  s_data,
    input  logic      m_ready,
    output logic      m_valid,
    output out_word_t m_data,
    input  ctrl_cmd_t cmd,
    output dp_sts_t   sts
);

    localparam int LIDX_W    = $clog2(LOCAL_ENTRIES);
    localparam int LC_DEPTH  = 1 << LOCAL_HISTORY_BITS;
    localparam int GC_DEPTH  = 1 << PATH_HISTORY_BITS;
    localparam int MAX_A     = (LOCAL_ENTRIES > LC_DEPTH) ? LOCAL_ENTRIES : LC_DEPTH;
    localparam int CLR_DEPTH = (MAX_A > GC_DEPTH) ? MAX_A : GC_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam int GC_W      = 2 * GLOBAL_CNT_BITS;
    localparam int LHB       = LOCAL_HISTORY_BITS;
    localparam int LCB       = LOCAL_COUNTER_BITS;
    localparam int PHB       = PATH_HISTORY_BITS;

    logic [CLR_W-1:0]  clr_cnt_reg;
    logic [PHB-1:0]    ph_reg;
    logic [LIDX_W-1:0] saved_idx_reg;
    logic [LHB-1:0]    saved_hist_reg;
    logic              saved_lg_reg;
    logic              saved_gg_reg;
    logic [LIDX_W-1:0] pend_idx_reg;
    logic              pend_taken_reg;
    logic              out_valid_reg;
    out_word_t         out_data_reg;

    logic [LHB-1:0]    lh_rdata;
    logic [LCB-1:0]    lc_rdata;
    logic [GC_W-1:0]   gc_rdata;

    logic              lh_we;
    logic [LIDX_W-1:0] lh_waddr;
    logic [LHB-1:0]    lh_wdata;
    logic              lc_we;
    logic [LHB-1:0]    lc_waddr;
    logic [LCB-1:0]    lc_wdata;
    logic [LHB-1:0]    lc_raddr;
    logic              gc_we;
    logic [PHB-1:0]    gc_waddr;
    logic [GC_W-1:0]   gc_wdata;

    logic [LCB-1:0]             lc_step;
    logic [GLOBAL_CNT_BITS-1:0] glob_cnt;
    logic [GLOBAL_CNT_BITS-1:0] choice_cnt;
    logic [GLOBAL_CNT_BITS-1:0] choice_new;
    logic                       glob_right;
    logic                       local_right;
    logic                       guess_local;
    logic                       guess_glob;

    assign glob_cnt    = gc_rdata[GLOBAL_CNT_BITS-1:0];
    assign choice_cnt  = gc_rdata[GC_W-1:GLOBAL_CNT_BITS];
    assign guess_local = lc_rdata[LCB-1];
    assign guess_glob  = glob_cnt[GLOBAL_CNT_BITS-1];
    assign glob_right  = (saved_gg_reg == pend_taken_reg);
    assign local_right = (saved_lg_reg == pend_taken_reg);

    always_comb begin
        lc_step = lc_rdata;
        if (pend_taken_reg) begin
            if (lc_rdata != '1) lc_step = lc_rdata + LCB'(1);
        end else begin
            if (lc_rdata != '0) lc_step = lc_rdata - LCB'(1);
        end
    end

    // choice moves only when exactly one predictor was right
    assign choice_new = (glob_right != local_right) ? sat2_step(choice_cnt, glob_right)
                                                    : choice_cnt;

    always_comb begin
        lh_we    = cmd.clear_wr || cmd.fin_upd;
        lh_waddr = cmd.clear_wr ? clr_cnt_reg[LIDX_W-1:0] : saved_idx_reg;
        lh_wdata = cmd.clear_wr ? '0 : {saved_hist_reg[LHB-2:0], pend_taken_reg};
        lc_we    = cmd.clear_wr || cmd.fin_upd;
        lc_waddr = cmd.clear_wr ? clr_cnt_reg[LHB-1:0] : saved_hist_reg;
        lc_wdata = cmd.clear_wr ? '0 : lc_step;
        lc_raddr = cmd.rd_pred_cnt ? lh_rdata : saved_hist_reg;
        gc_we    = cmd.clear_wr || cmd.fin_upd;
        gc_waddr = cmd.clear_wr ? clr_cnt_reg[PHB-1:0] : ph_reg;
        gc_wdata = cmd.clear_wr ? '0
                 : {choice_new, sat2_step(glob_cnt, pend_taken_reg)};
    end

    tbp_ram #(.WIDTH(LHB), .DEPTH(LOCAL_ENTRIES)) u_lh_ram (
        .aclk  (aclk),
        .we    (lh_we),
        .waddr (lh_waddr),
        .wdata (lh_wdata),
        .re    (cmd.rd_hist),
        .raddr (s_data.instr_addr[2 +: LIDX_W]),
        .rdata (lh_rdata)
    );

    tbp_ram #(.WIDTH(LCB), .DEPTH(LC_DEPTH)) u_lc_ram (
        .aclk  (aclk),
        .we    (lc_we),
        .waddr (lc_waddr),
        .wdata (lc_wdata),
        .re    (cmd.rd_pred_cnt || cmd.rd_upd_cnt),
        .raddr (lc_raddr),
        .rdata (lc_rdata)
    );

    // global counter in the low half, choice counter in the high half
    tbp_ram #(.WIDTH(GC_W), .DEPTH(GC_DEPTH)) u_gc_ram (
        .aclk  (aclk),
        .we    (gc_we),
        .waddr (gc_waddr),
        .wdata (gc_wdata),
        .re    (cmd.rd_pred_cnt || cmd.rd_upd_cnt),
        .raddr (ph_reg),
        .rdata (gc_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg    <= '0;
            ph_reg         <= '0;
            saved_idx_reg  <= '0;
            saved_hist_reg <= '0;
            saved_lg_reg   <= 1'b0;
            saved_gg_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.clear_wr) begin
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
            end
            if (cmd.fin_pred) begin
                saved_idx_reg  <= pend_idx_reg;
                saved_hist_reg <= lh_rdata;
                saved_lg_reg   <= guess_local;
                saved_gg_reg   <= guess_glob;
            end
            if (cmd.fin_upd) begin
                ph_reg <= {ph_reg[PHB-2:0], pend_taken_reg};
            end
            if (cmd.fin_pred || cmd.fin_upd) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_hist) begin
            pend_idx_reg <= s_data.instr_addr[2 +: LIDX_W];
        end
        if (cmd.rd_upd_cnt) begin
            pend_taken_reg <= s_data.branch_taken;
        end
        if (cmd.fin_pred) begin
            out_data_reg.predict_taken <= choice_cnt[GLOBAL_CNT_BITS-1] ? guess_glob
                                                                         : guess_local;
            out_data_reg.is_prediction <= 1'b1;
        end else if (cmd.fin_upd) begin
            out_data_reg <= '0;
        end
    end

    assign sts.clear_last = (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1));
    assign sts.out_busy   = out_valid_reg && !m_ready;
    assign m_valid        = out_valid_reg;
    assign m_data         = out_data_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fin_pred || cmd.fin_upd) |-> !(out_valid_reg && !m_ready))
        else $error("output word overwritten before it was taken");

    a_fin_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fin_pred || cmd.fin_upd) |=> out_valid_reg)
        else $error("finished word not presented");

    a_no_clear_write_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_wr |-> !(cmd.fin_upd || cmd.rd_hist || cmd.rd_upd_cnt))
        else $error("item activity during clear pass");
`endif

endmodule

// ----- rtl/tournament_branch_predictor.sv -----
`timescale 1ns / 1ps
// tournament branch predictor: local history, local / global / choice counters
// usage: s_ channel takes predict or update words, m_ channel returns one word per input word
// predict (command 0): looks up history by instr_addr[11:2], returns predict_taken with
//   is_prediction = 1; the history is read at accept, then the counters, then the select
//   loads the result register once the output is free; no new word is taken meanwhile
// update (command 1): trains with branch_taken using the context of the last predict;
//   the counters are read at accept, then history and counters are written back as the result
//   register loads, once the output is free; no new word is taken meanwhile; the result word is all zero
// this order is set by the registered-read rams: history must be read before the counters
// s_ready is high only while no word is in flight; the result waits in an output register
// after reset the block clears every ram one entry per cycle, walking
//   max(LOCAL_ENTRIES, 2**LOCAL_HISTORY_BITS, 2**PATH_HISTORY_BITS) addresses (4096 by default);
//   s_ready stays low until the pass is done
// when the receiver stalls the finished word holds on m_data and the block waits before
// committing the next word's writes; LOCAL_ENTRIES must be a power of two
// depends on tbp_pkg, tbp_ctrl, tbp_datapath, tbp_ram

module tournament_branch_predictor
    import tbp_pkg::*;
#(
    parameter int LOCAL_ENTRIES      = 1024,
    parameter int LOCAL_HISTORY_BITS = 10,
    parameter int LOCAL_COUNTER_BITS = 3,
    parameter int PATH_HISTORY_BITS  = 12
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    tbp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_data.command),
        .s_ready   (s_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tbp_datapath #(
        .LOCAL_ENTRIES      (LOCAL_ENTRIES),
        .LOCAL_HISTORY_BITS (LOCAL_HISTORY_BITS),
        .LOCAL_COUNTER_BITS (LOCAL_COUNTER_BITS),
        .PATH_HISTORY_BITS  (PATH_HISTORY_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule
